// ----- sv/primitive_assembler_assert.svh -----
`ifndef PRIMITIVE_ASSEMBLER_ASSERT_SVH
`define PRIMITIVE_ASSEMBLER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("primitive_assembler: check failed");

// Checked on every clock edge, reset included.
`define PA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("primitive_assembler: check failed");

`endif

// ----- sv/pa_pkg.sv -----
`timescale 1ns / 1ps

package pa_pkg;

	// Width of stored vertex indices; ports stay 16 bits wide
	localparam int INDEX_BITS = 16;
	localparam int IDX_W      = (INDEX_BITS < 16) ? INDEX_BITS : 16;

	localparam logic [15:0] SAT16 = 16'hFFFF;

	typedef logic [IDX_W-1:0] idx_t;

	// Primitive type codes
	typedef enum logic [1:0] {
		OP_LIST  = 2'd0,
		OP_STRIP = 2'd1,
		OP_FAN   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Classified request passed from the front end to the back end
	typedef struct packed {
		op_t         op;
		idx_t        vidx;
		logic [15:0] material;
		logic        opens;
		logic        last;
	} pa_item_t;

	// Zero-extend a stored index to the 16-bit port width
	function automatic logic [15:0] idx_to_port(idx_t x);
		logic [15:0] r;
		r = '0;
		r[IDX_W-1:0] = x;
		return r;
	endfunction

endpackage

// ----- sv/pa_front.sv -----
`timescale 1ns / 1ps

module pa_front import pa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] vertex_index,
	input  logic [15:0] material,
	input  logic        first_in_primitive,
	input  logic        last_in_primitive,
	output logic        push,
	output pa_item_t    item
);

	logic start_q;
	op_t  op_dec;

	assign push = item_valid && !item_stall;

	// Decode the primitive type
	always_comb begin
		case (opcode)
			OP_LIST:  op_dec = OP_LIST;
			OP_STRIP: op_dec = OP_STRIP;
			OP_FAN:   op_dec = OP_FAN;
			default:  op_dec = OP_NONE;
		endcase
	end

	// An item opens a primitive on its first mark, after a last mark or after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (push) begin
			start_q <= last_in_primitive;
		end
	end

	always_comb begin
		item.op       = op_dec;
		item.vidx     = vertex_index[IDX_W-1:0];
		item.material = material;
		item.opens    = first_in_primitive || start_q;
		item.last     = last_in_primitive;
	end

endmodule

// ----- sv/pa_queue.sv -----
`timescale 1ns / 1ps
`include "primitive_assembler_assert.svh"

module pa_queue import pa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pa_item_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output pa_item_t head_item
);

	pa_item_t   entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entries_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`PA_ASSERT(q_count_range, count_q != 2'd3)
	`PA_ASSERT(q_no_overflow, push |-> !full)
	`PA_ASSERT(q_no_underflow, pop |-> head_valid)
	`PA_ASSERT(q_ptr_track, (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)

endmodule

// ----- sv/pa_back.sv -----
`timescale 1ns / 1ps
`include "primitive_assembler_assert.svh"

module pa_back import pa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  pa_item_t    head_item,
	output logic        pop,
	output logic        tri_valid,
	input  logic        tri_stall,
	output logic [15:0] corner_a,
	output logic [15:0] corner_b,
	output logic [15:0] corner_c,
	output logic [15:0] material_out,
	output logic [15:0] triangle_ordinal,
	output logic        end_of_primitive
);

	// Assembly state
	idx_t        pivot_q, older_q, newer_q;
	logic [1:0]  pos_q;      // indices seen, saturating at 2
	logic [15:0] tc_q;
	logic [1:0]  phase_q;
	logic        odd_q;

	// Output register
	logic        out_valid_q;
	idx_t        a_q, b_q, c_q;
	logic [15:0] mat_q, ord_q;
	logic        eop_q;

	logic        emit;
	idx_t        a_n, b_n, c_n, pivot_n;
	logic [1:0]  pos_e, phase_e, phase_n, pos_n;
	logic [15:0] tc_e, tc_n;
	logic        odd_e, odd_n;

	// Take the next request once the output register is free or draining
	assign pop = head_valid && (!out_valid_q || !tri_stall);

	// Per-request state update
	always_comb begin
		pos_e   = head_item.opens ? 2'd0  : pos_q;
		tc_e    = head_item.opens ? 16'd0 : tc_q;
		phase_e = head_item.opens ? 2'd0  : phase_q;
		odd_e   = head_item.opens ? 1'b0  : odd_q;
		pivot_n = (pos_e == 2'd0) ? head_item.vidx : pivot_q;
		emit    = 1'b0;
		a_n     = older_q;
		b_n     = newer_q;
		c_n     = head_item.vidx;
		phase_n = phase_e;
		odd_n   = odd_e;
		case (head_item.op)
			OP_LIST: begin
				if (phase_e == 2'd2) begin
					emit    = 1'b1;
					phase_n = 2'd0;
				end else begin
					phase_n = phase_e + 2'd1;
				end
			end
			OP_STRIP: begin
				if (pos_e == 2'd2) begin
					emit  = 1'b1;
					odd_n = !odd_e;
					if (odd_e) begin
						a_n = head_item.vidx;
						c_n = older_q;
					end
				end
			end
			OP_FAN: begin
				if (pos_e == 2'd2) begin
					emit = 1'b1;
					a_n  = pivot_n;
				end
			end
			default: emit = 1'b0;
		endcase
		tc_n  = (emit && tc_e != SAT16) ? tc_e + 16'd1 : tc_e;
		pos_n = (pos_e == 2'd2) ? pos_e : pos_e + 2'd1;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= '0;
			older_q <= '0;
			newer_q <= '0;
			pos_q   <= 2'd0;
			tc_q    <= 16'd0;
			phase_q <= 2'd0;
			odd_q   <= 1'b0;
		end else if (pop) begin
			pivot_q <= pivot_n;
			older_q <= newer_q;
			newer_q <= head_item.vidx;
			pos_q   <= pos_n;
			tc_q    <= tc_n;
			phase_q <= phase_n;
			odd_q   <= odd_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (!tri_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			a_q   <= a_n;
			b_q   <= b_n;
			c_q   <= c_n;
			mat_q <= head_item.material;
			ord_q <= tc_e;
			eop_q <= head_item.last;
		end
	end

	assign tri_valid        = out_valid_q;
	assign corner_a         = idx_to_port(a_q);
	assign corner_b         = idx_to_port(b_q);
	assign corner_c         = idx_to_port(c_q);
	assign material_out     = mat_q;
	assign triangle_ordinal = ord_q;
	assign end_of_primitive = eop_q;

	`PA_ASSERT(bk_phase_range, phase_q != 2'd3)
	`PA_ASSERT(bk_pos_range, pos_q != 2'd3)
	`PA_ASSERT(bk_open_no_tri, (pop && head_item.opens && head_item.op != OP_LIST) |-> !emit)
	`PA_ASSERT(bk_stall_hold, (tri_valid && tri_stall) |=> tri_valid && $stable(ord_q))

endmodule

// ----- sv/primitive_assembler.sv -----
`timescale 1ns / 1ps

// Primitive assembler: turns a stream of vertex indices (triangle list, strip
// or fan, one index per request) into triangles, at most one per index. It
// takes one index per clock cycle sustained unless tri_stall is high; each
// triangle is registered at the output as its completing index is popped,
// the limit being the update of the assembly state (pivot, two previous
// indices, position, list phase, strip parity, triangle counter) in the back
// end. A two-entry queue separates index intake from assembly, so a stalled
// output holds at most two further indices before item_stall rises. A request
// after one marked last opens a new primitive even without its first mark;
// type 3 requests produce nothing but still shift the previous indices.
module primitive_assembler import pa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] vertex_index,
	input  logic [15:0] material,
	input  logic        first_in_primitive,
	input  logic        last_in_primitive,
	output logic        tri_valid,
	input  logic        tri_stall,
	output logic [15:0] corner_a,
	output logic [15:0] corner_b,
	output logic [15:0] corner_c,
	output logic [15:0] material_out,
	output logic [15:0] triangle_ordinal,
	output logic        end_of_primitive
);

	logic     push, pop, full, head_valid;
	pa_item_t push_item, head_item;

	assign item_stall = full;

	pa_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.opcode             (opcode),
		.vertex_index       (vertex_index),
		.material           (material),
		.first_in_primitive (first_in_primitive),
		.last_in_primitive  (last_in_primitive),
		.push               (push),
		.item               (push_item)
	);

	pa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	pa_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_item        (head_item),
		.pop              (pop),
		.tri_valid        (tri_valid),
		.tri_stall        (tri_stall),
		.corner_a         (corner_a),
		.corner_b         (corner_b),
		.corner_c         (corner_c),
		.material_out     (material_out),
		.triangle_ordinal (triangle_ordinal),
		.end_of_primitive (end_of_primitive)
	);

endmodule
